// ===== hdl/rsfr_pkg.sv =====
// shared types, character codes and helpers for the radio state frame receiver
`timescale 1ns / 1ps

package rsfr_pkg;

    localparam logic [7:0] CHAR_STATE_START = 8'h7B;
    localparam logic [7:0] CHAR_ERR_START   = 8'h21;
    localparam logic [7:0] CHAR_AMP         = 8'h26;
    localparam logic [7:0] CHAR_SLASH       = 8'h2F;
    localparam logic [7:0] CHAR_UPPER_A     = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z     = 8'h5A;
    localparam logic [7:0] CHAR_LOWER_A     = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z     = 8'h7A;
    localparam logic [7:0] CHAR_DIGIT_0     = 8'h30;
    localparam logic [7:0] CHAR_DIGIT_9     = 8'h39;
    localparam logic [7:0] ODD_BIT_MASK     = 8'hAA;
    localparam logic [7:0] EVEN_BIT_MASK    = 8'h55;
    localparam logic [5:0] SYM_AMP          = 6'd62;
    localparam logic [5:0] SYM_SLASH        = 6'd63;
    localparam logic [5:0] SYM_LOWER_BASE   = 6'd26;
    localparam logic [5:0] SYM_DIGIT_BASE   = 6'd52;
    localparam int         FRAME_SYMBOLS    = 8;

    typedef struct packed {
        logic       is_state_start;
        logic       is_err_start;
        logic       is_sym;
        logic [5:0] value;
        logic [4:0] weight;
    } t_dec;

    typedef struct packed {
        logic [3:0]  boards_connected;
        logic [1:0]  injector_valve;
        logic [1:0]  vent_valve;
        logic [9:0]  tank_press;
        logic        bus_powered;
        logic        errors_present;
        logic [13:0] bus_battery_mv;
        logic [13:0] vent_battery_mv;
    } t_telemetry;

    function automatic logic [2:0] popcount8(input logic [7:0] v);
        logic [2:0] n;
        n = 3'd0;
        for (int k = 0; k < 8; k++) begin
            n = n + {2'b00, v[k]};
        end
        return n;
    endfunction

endpackage

// ===== hdl/rsfr_sym_decode.sv =====
// byte classifier: frame starts, alphabet value and checksum weight
`timescale 1ns / 1ps

module rsfr_sym_decode
    import rsfr_pkg::*;
(
    input  logic [7:0] i_byte,
    output t_dec       o_dec
);

    logic [7:0] w_off_upper;
    logic [7:0] w_off_lower;
    logic [7:0] w_off_digit;
    logic [2:0] w_odd_cnt;
    logic [2:0] w_even_cnt;

    assign w_off_upper = i_byte - CHAR_UPPER_A;
    assign w_off_lower = i_byte - CHAR_LOWER_A;
    assign w_off_digit = i_byte - CHAR_DIGIT_0;
    assign w_odd_cnt   = popcount8(i_byte & ODD_BIT_MASK);
    assign w_even_cnt  = popcount8(i_byte & EVEN_BIT_MASK);

    always_comb begin
        o_dec.is_state_start = (i_byte == CHAR_STATE_START);
        o_dec.is_err_start   = (i_byte == CHAR_ERR_START);
        o_dec.is_sym         = 1'b1;
        o_dec.value          = 6'd0;
        if (i_byte >= CHAR_UPPER_A && i_byte <= CHAR_UPPER_Z) begin
            o_dec.value = w_off_upper[5:0];
        end else if (i_byte >= CHAR_LOWER_A && i_byte <= CHAR_LOWER_Z) begin
            o_dec.value = w_off_lower[5:0] + SYM_LOWER_BASE;
        end else if (i_byte >= CHAR_DIGIT_0 && i_byte <= CHAR_DIGIT_9) begin
            o_dec.value = w_off_digit[5:0] + SYM_DIGIT_BASE;
        end else if (i_byte == CHAR_AMP) begin
            o_dec.value = SYM_AMP;
        end else if (i_byte == CHAR_SLASH) begin
            o_dec.value = SYM_SLASH;
        end else begin
            o_dec.is_sym = 1'b0;
        end
        o_dec.weight = {1'b0, w_odd_cnt, 1'b0} + ({2'b00, w_even_cnt} << 1)
                     + {2'b00, w_even_cnt};
    end

endmodule

// ===== hdl/rsfr_frame_ctrl.sv =====
// frame state, symbol store, checksum and telemetry unpack
`timescale 1ns / 1ps

module rsfr_frame_ctrl
    import rsfr_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_en,
    input  t_dec       i_dec,
    output logic       o_hit,
    output t_telemetry o_telem
);

    localparam logic [1:0] MODE_IDLE  = 2'd0;
    localparam logic [1:0] MODE_STATE = 2'd1;
    localparam logic [1:0] MODE_ERROR = 2'd2;
    localparam logic [3:0] COUNT_FULL = 4'(FRAME_SYMBOLS);

    logic [1:0] r_mode, n_mode;
    logic [3:0] r_count, n_count;
    logic [5:0] r_sum, n_sum;
    logic [5:0] r_sym [FRAME_SYMBOLS];
    logic       w_store;

    always_comb begin
        n_mode  = r_mode;
        n_count = r_count;
        n_sum   = r_sum;
        w_store = 1'b0;
        o_hit   = 1'b0;
        if (i_dec.is_state_start) begin
            n_mode  = MODE_STATE;
            n_count = 4'd0;
            n_sum   = 6'd0;
        end else if (i_dec.is_err_start) begin
            n_mode  = MODE_ERROR;
            n_count = 4'd0;
            n_sum   = 6'd0;
        end else if (i_dec.is_sym) begin
            unique case (r_mode)
                MODE_ERROR: begin
                    n_count = r_count + 4'd1;
                    if (n_count >= COUNT_FULL) begin
                        n_mode  = MODE_IDLE;
                        n_count = 4'd0;
                    end
                end
                MODE_STATE: begin
                    if (r_count < COUNT_FULL) begin
                        w_store = 1'b1;
                        n_sum   = r_sum + {1'b0, i_dec.weight};
                        n_count = r_count + 4'd1;
                    end else begin
                        n_mode  = MODE_IDLE;
                        n_count = 4'd0;
                        n_sum   = 6'd0;
                        o_hit   = (i_dec.value == r_sum);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_IDLE;
            r_count <= 4'd0;
            r_sum   <= 6'd0;
        end else if (i_en) begin
            r_mode  <= n_mode;
            r_count <= n_count;
            r_sum   <= n_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en && w_store) begin
            r_sym[r_count[2:0]] <= i_dec.value;
        end
    end

    always_comb begin
        o_telem.boards_connected = r_sym[0][5:2];
        o_telem.injector_valve   = r_sym[0][1:0];
        o_telem.vent_valve       = r_sym[1][5:4];
        o_telem.tank_press       = {r_sym[1][3:0], r_sym[2]};
        o_telem.bus_powered      = r_sym[3][5];
        o_telem.errors_present   = r_sym[3][4];
        o_telem.bus_battery_mv   = {r_sym[3][3:0], r_sym[4], r_sym[5][5:2]};
        o_telem.vent_battery_mv  = {r_sym[5][1:0], r_sym[6], r_sym[7]};
    end

endmodule

// ===== hdl/radio_state_frame_receiver.sv =====
// top level: input register, frame decode and telemetry result register
//
// channel  direction  handshake           payload
// input    in         i_valid / o_ready   i_rx_byte
// result   out        o_valid / i_ready   o_boards_connected .. o_vent_battery_mv
//
// one word per cycle sustained while the result is not stalled; o_valid rises after a good
// checksum word is accepted, once it has passed the input register, then the result register
// reset clears frame mode, count, sum and both valid flags
// a stalled result holds the word in the input register, which in turn
// drops o_ready until the result is taken
`timescale 1ns / 1ps

module radio_state_frame_receiver
    import rsfr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_rx_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [3:0]  o_boards_connected,
    output logic [1:0]  o_injector_valve,
    output logic [1:0]  o_vent_valve,
    output logic [9:0]  o_tank_press,
    output logic        o_bus_powered,
    output logic        o_errors_present,
    output logic [13:0] o_bus_battery_mv,
    output logic [13:0] o_vent_battery_mv
);

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_out_valid, n_out_valid;
    t_telemetry r_out;
    t_dec       w_dec;
    t_telemetry w_telem;
    logic       w_hit;
    logic       w_fire;

    assign w_fire  = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_in_valid || w_fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_byte <= i_rx_byte;
        end
    end

    rsfr_sym_decode u_decode (
        .i_byte (r_in_byte),
        .o_dec  (w_dec)
    );

    rsfr_frame_ctrl u_frame (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_fire),
        .i_dec   (w_dec),
        .o_hit   (w_hit),
        .o_telem (w_telem)
    );

    always_comb begin
        n_out_valid = r_out_valid && !i_ready;
        if (w_fire && w_hit) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire && w_hit) begin
            r_out <= w_telem;
        end
    end

    assign o_valid            = r_out_valid;
    assign o_boards_connected = r_out.boards_connected;
    assign o_injector_valve   = r_out.injector_valve;
    assign o_vent_valve       = r_out.vent_valve;
    assign o_tank_press       = r_out.tank_press;
    assign o_bus_powered      = r_out.bus_powered;
    assign o_errors_present   = r_out.errors_present;
    assign o_bus_battery_mv   = r_out.bus_battery_mv;
    assign o_vent_battery_mv  = r_out.vent_battery_mv;

    a_no_advance_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_ready) |-> !w_fire)
        else $error("frame logic advanced while result was stalled");

    a_result_from_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !$past(o_valid)) |-> $past(w_fire && w_hit))
        else $error("result appeared without a checksum match");

    a_hit_is_symbol: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_hit |-> (w_dec.is_sym && !w_dec.is_state_start && !w_dec.is_err_start))
        else $error("checksum match on a non alphabet word");

endmodule

// ===== bench/radio_state_frame_receiver_checker.sv =====
// telemetry predictor and result checker for the radio state frame receiver bench
`timescale 1ns / 1ps

module radio_state_frame_receiver_checker
    import rsfr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [7:0]  i_rx_byte,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [3:0]  i_boards_connected,
    input  logic [1:0]  i_injector_valve,
    input  logic [1:0]  i_vent_valve,
    input  logic [9:0]  i_tank_press,
    input  logic        i_bus_powered,
    input  logic        i_errors_present,
    input  logic [13:0] i_bus_battery_mv,
    input  logic [13:0] i_vent_battery_mv,
    output int          o_fail_count,
    output int          o_pending
);

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_STATE,
        MODE_ERROR
    } t_mode;

    t_mode       mode = MODE_IDLE;
    logic [3:0]  taken_chars = '0;
    logic [5:0]  symbols [FRAME_SYMBOLS];
    logic [5:0]  frame_sum = '0;
    t_telemetry  telemetry_due [$];
    int          fails = 0;

    task automatic report(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        fails++;
    endtask

    // {is_symbol, value}
    function automatic logic [6:0] char_symbol(input logic [7:0] c);
        if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z)
            return {1'b1, 6'(c - CHAR_UPPER_A)};
        if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z)
            return {1'b1, 6'(c - CHAR_LOWER_A) + SYM_LOWER_BASE};
        if (c >= CHAR_DIGIT_0 && c <= CHAR_DIGIT_9)
            return {1'b1, 6'(c - CHAR_DIGIT_0) + SYM_DIGIT_BASE};
        if (c == CHAR_AMP)
            return {1'b1, SYM_AMP};
        if (c == CHAR_SLASH)
            return {1'b1, SYM_SLASH};
        return 7'd0;
    endfunction

    function automatic logic [5:0] char_weight(input logic [7:0] c);
        int w;
        w = 2 * $countones(c & ODD_BIT_MASK) + 3 * $countones(c & EVEN_BIT_MASK);
        return 6'(w);
    endfunction

    task automatic absorb_byte(input logic [7:0] c);
        logic [6:0] dec;
        t_telemetry t;
        dec = char_symbol(c);
        if (c == CHAR_STATE_START) begin
            mode = MODE_STATE;
            taken_chars = '0;
            frame_sum = '0;
        end else if (c == CHAR_ERR_START) begin
            mode = MODE_ERROR;
            taken_chars = '0;
            frame_sum = '0;
        end else if (dec[6] && mode == MODE_ERROR) begin
            taken_chars = taken_chars + 4'd1;
            if (taken_chars >= FRAME_SYMBOLS) begin
                mode = MODE_IDLE;
                taken_chars = '0;
            end
        end else if (dec[6] && mode == MODE_STATE) begin
            if (taken_chars < FRAME_SYMBOLS) begin
                symbols[taken_chars[2:0]] = dec[5:0];
                frame_sum = frame_sum + char_weight(c);
                taken_chars = taken_chars + 4'd1;
            end else begin
                mode = MODE_IDLE;
                taken_chars = '0;
                if (dec[5:0] == frame_sum) begin
                    t.boards_connected = symbols[0][5:2];
                    t.injector_valve   = symbols[0][1:0];
                    t.vent_valve       = symbols[1][5:4];
                    t.tank_press       = {symbols[1][3:0], symbols[2]};
                    t.bus_powered      = symbols[3][5];
                    t.errors_present   = symbols[3][4];
                    t.bus_battery_mv   = {symbols[3][3:0], symbols[4], symbols[5][5:2]};
                    t.vent_battery_mv  = {symbols[5][1:0], symbols[6], symbols[7]};
                    telemetry_due.push_back(t);
                end
                frame_sum = '0;
            end
        end
    endtask

    task automatic compare_field(input string name, input logic [13:0] got,
                                 input logic [13:0] want);
        if (got !== want)
            report($sformatf("%s got %0d expected %0d", name, got, want));
    endtask

    task automatic check_telemetry();
        t_telemetry want;
        if (telemetry_due.size() == 0) begin
            report("telemetry word with none expected");
        end else begin
            want = telemetry_due.pop_front();
            compare_field("boards_connected", 14'(i_boards_connected),
                          14'(want.boards_connected));
            compare_field("injector_valve", 14'(i_injector_valve), 14'(want.injector_valve));
            compare_field("vent_valve", 14'(i_vent_valve), 14'(want.vent_valve));
            compare_field("tank_press", 14'(i_tank_press), 14'(want.tank_press));
            compare_field("bus_powered", 14'(i_bus_powered), 14'(want.bus_powered));
            compare_field("errors_present", 14'(i_errors_present), 14'(want.errors_present));
            compare_field("bus_battery_mv", i_bus_battery_mv, want.bus_battery_mv);
            compare_field("vent_battery_mv", i_vent_battery_mv, want.vent_battery_mv);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            mode = MODE_IDLE;
            taken_chars = '0;
            frame_sum = '0;
            telemetry_due.delete();
        end else begin
            if (i_out_valid && i_out_ready)
                check_telemetry();
            if (i_in_valid && i_in_ready)
                absorb_byte(i_rx_byte);
        end
        o_pending <= telemetry_due.size();
        o_fail_count <= fails;
    end

endmodule

// ===== bench/radio_state_frame_receiver_test.sv =====
// stimulus, watchdog and verdict for the radio state frame receiver bench
`timescale 1ns / 1ps

module radio_state_frame_receiver_test;
    import rsfr_pkg::*;

    localparam int BYTE_TARGET  = 1400;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 10;
    localparam int HOLD_OFF     = 300;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        i_ready = 1'b0;
    logic [7:0]  i_rx_byte = '0;
    logic        o_ready;
    logic        o_valid;
    logic [3:0]  o_boards_connected;
    logic [1:0]  o_injector_valve;
    logic [1:0]  o_vent_valve;
    logic [9:0]  o_tank_press;
    logic        o_bus_powered;
    logic        o_errors_present;
    logic [13:0] o_bus_battery_mv;
    logic [13:0] o_vent_battery_mv;
    int          fail_count;
    int          pending;
    int          sent = 0;
    int          stall_cycles = 0;

    radio_state_frame_receiver dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_ready            (o_ready),
        .i_rx_byte          (i_rx_byte),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_boards_connected (o_boards_connected),
        .o_injector_valve   (o_injector_valve),
        .o_vent_valve       (o_vent_valve),
        .o_tank_press       (o_tank_press),
        .o_bus_powered      (o_bus_powered),
        .o_errors_present   (o_errors_present),
        .o_bus_battery_mv   (o_bus_battery_mv),
        .o_vent_battery_mv  (o_vent_battery_mv)
    );

    radio_state_frame_receiver_checker u_checker (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_valid),
        .i_in_ready         (o_ready),
        .i_rx_byte          (i_rx_byte),
        .i_out_valid        (o_valid),
        .i_out_ready        (i_ready),
        .i_boards_connected (o_boards_connected),
        .i_injector_valve   (o_injector_valve),
        .i_vent_valve       (o_vent_valve),
        .i_tank_press       (o_tank_press),
        .i_bus_powered      (o_bus_powered),
        .i_errors_present   (o_errors_present),
        .i_bus_battery_mv   (o_bus_battery_mv),
        .i_vent_battery_mv  (o_vent_battery_mv),
        .o_fail_count       (fail_count),
        .o_pending          (pending)
    );

    always #10 i_clk = ~i_clk;

    function automatic logic [7:0] sym_char(input logic [5:0] v);
        if (v < SYM_LOWER_BASE)
            return CHAR_UPPER_A + 8'(v);
        if (v < SYM_DIGIT_BASE)
            return CHAR_LOWER_A + 8'(v - SYM_LOWER_BASE);
        if (v < SYM_AMP)
            return CHAR_DIGIT_0 + 8'(v - SYM_DIGIT_BASE);
        if (v == SYM_AMP)
            return CHAR_AMP;
        return CHAR_SLASH;
    endfunction

    function automatic logic [5:0] sym_weight(input logic [7:0] c);
        logic [5:0] w;
        w = '0;
        for (int k = 0; k < 8; k++) begin
            if (c[k])
                w = w + ((k % 2) ? 6'd2 : 6'd3);
        end
        return w;
    endfunction

    // any byte outside the alphabet that starts no frame
    function automatic logic [7:0] quiet_byte();
        case ($urandom_range(0, 5))
            0: return 8'($urandom_range(0, CHAR_ERR_START - 1));
            1: return 8'($urandom_range(CHAR_ERR_START + 1, CHAR_AMP - 1));
            2: return 8'($urandom_range(CHAR_AMP + 1, CHAR_SLASH - 1));
            3: return 8'($urandom_range(CHAR_DIGIT_9 + 1, CHAR_UPPER_A - 1));
            4: return 8'($urandom_range(CHAR_UPPER_Z + 1, CHAR_LOWER_A - 1));
            default: return 8'($urandom_range(CHAR_STATE_START + 1, 255));
        endcase
    endfunction

    function automatic logic [47:0] random_symbols();
        logic [47:0] s;
        int shape;
        int pick;
        shape = $urandom_range(0, 9);
        for (int k = 0; k < FRAME_SYMBOLS; k++) begin
            pick = $urandom_range(0, 9);
            if (shape == 0 || (shape > 1 && pick == 0))
                s[6*k +: 6] = '0;
            else if (shape == 1 || pick == 1)
                s[6*k +: 6] = '1;
            else
                s[6*k +: 6] = 6'($urandom_range(0, 63));
        end
        return s;
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic counted);
        int gap;
        if ((sent / 150) % 3 == 1)
            gap = 0;
        else
            gap = $urandom_range(0, 18);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_rx_byte <= b;
        do @(posedge i_clk); while (!(i_valid && o_ready));
        if (counted)
            sent++;
    endtask

    task automatic send_state_frame(input logic [47:0] syms, input int length,
                                    input logic good_sum, input int noise_pct);
        logic [5:0] acc;
        logic [7:0] c;
        acc = '0;
        send_byte(CHAR_STATE_START, 1'b1);
        for (int k = 0; k < length; k++) begin
            if ($urandom_range(0, 99) < noise_pct)
                send_byte(quiet_byte(), 1'b0);
            c = sym_char(syms[6*k +: 6]);
            acc = acc + sym_weight(c);
            send_byte(c, 1'b1);
        end
        if (length == FRAME_SYMBOLS) begin
            if (!good_sum)
                acc = acc + 6'($urandom_range(1, 63));
            send_byte(sym_char(acc), 1'b1);
        end
    endtask

    task automatic send_error_frame(input int length, input int noise_pct);
        send_byte(CHAR_ERR_START, 1'b1);
        for (int k = 0; k < length; k++) begin
            if ($urandom_range(0, 99) < noise_pct)
                send_byte(quiet_byte(), 1'b0);
            send_byte(sym_char(6'($urandom_range(0, 63))), 1'b1);
        end
    endtask

    initial begin : byte_source
        int pick;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // ignored bytes while idle, abandoned frame, max telemetry, full error frame
        send_byte(8'hFF, 1'b0);
        send_byte(CHAR_LOWER_Z, 1'b0);
        send_byte(CHAR_STATE_START, 1'b1);
        send_byte(CHAR_SLASH, 1'b1);
        send_state_frame('1, FRAME_SYMBOLS, 1'b1, 0);
        send_byte(quiet_byte(), 1'b0);
        send_error_frame(FRAME_SYMBOLS, 0);
        send_byte(CHAR_UPPER_A, 1'b0);

        while (sent < BYTE_TARGET) begin
            pick = $urandom_range(0, 99);
            if (pick < 65)
                send_state_frame(random_symbols(), FRAME_SYMBOLS, 1'b1, 8);
            else if (pick < 75)
                send_state_frame(random_symbols(), FRAME_SYMBOLS, 1'b0, 8);
            else if (pick < 84)
                send_error_frame(($urandom_range(0, 3) == 0) ? $urandom_range(0, 7)
                                                            : FRAME_SYMBOLS, 8);
            else if (pick < 93)
                send_state_frame(random_symbols(), $urandom_range(0, 7), 1'b1, 8);
            else
                repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)), 1'b0);
        end
        i_valid <= 1'b0;

        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial begin : telemetry_sink
        int taken;
        int gap;
        taken = 0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            // one long hold-off lets the block fill up and stall its input
            if (taken == 30)
                gap = HOLD_OFF;
            else if ((taken / 20) % 3 == 1)
                gap = 0;
            else
                gap = $urandom_range(0, 18);
            if (gap > 0) begin
                i_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!(o_valid && i_ready));
            taken++;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

endmodule

// ===== radio_state_frame_receiver.f =====
hdl/rsfr_pkg.sv
hdl/rsfr_sym_decode.sv
hdl/rsfr_frame_ctrl.sv
hdl/radio_state_frame_receiver.sv
bench/radio_state_frame_receiver_checker.sv
bench/radio_state_frame_receiver_test.sv
